FILE: hdl/modbus_velocity_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus velocity frame parser
// Clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef MODBUS_VELOCITY_FRAME_PARSER_MACROS_SVH
`define MODBUS_VELOCITY_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define FVP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fvp assertion failed");

// next-cycle implication
`define FVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fvp assertion failed");

`endif

FILE: hdl/fvp_pkg.sv
// ----------------------------------------------------------------------------
// fvp_pkg
// Types, constants and the CRC16-Modbus byte update for the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fvp_pkg;

    localparam int FRAME_LENGTH = 9;

    localparam logic [3:0] POS_HDR0 = 4'd0;
    localparam logic [3:0] POS_HDR1 = 4'd1;
    localparam logic [3:0] POS_HDR2 = 4'd2;
    localparam logic [3:0] POS_B3   = 4'd3;
    localparam logic [3:0] POS_B5   = 4'd5;
    localparam logic [3:0] POS_B6   = 4'd6;
    localparam logic [3:0] POS_B7   = 4'd7;
    localparam logic [3:0] POS_LAST = 4'(FRAME_LENGTH - 1);

    localparam logic [7:0] HDR_ADDR  = 8'h00;
    localparam logic [7:0] HDR_FUNC  = 8'h03;
    localparam logic [7:0] HDR_COUNT = 8'h04;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // velocity = ((word >>> 12) * 25) / 109, |x*25| < 2^24
    localparam int RAW_W   = 20;
    localparam int SCL_W   = 25;
    localparam int MAG_W   = 24;
    localparam int RCP_SH  = 31;
    localparam int PROD_W  = MAG_W + SCL_W;
    localparam int QUO_W   = 17;
    localparam logic signed [SCL_W-1:0] SCALE_MUL = 25'sd25;
    // ceil(2^31 / 109); exact for all magnitudes below 2^24
    localparam logic [SCL_W-1:0] DIV_RECIP = 25'd19701685;
    localparam logic signed [QUO_W:0] VEL_MAX = 18'sd32767;
    localparam logic signed [QUO_W:0] VEL_MIN = -18'sd32768;

    typedef struct packed {
        logic                 crc_match;
        logic [RAW_W-1:0]     speed_raw;
    } fvp_frame_t;

    typedef struct packed {
        logic       valid;
        fvp_frame_t frame;
    } fvp_push_t;

    typedef struct packed {
        logic valid;
        logic full;
    } fvp_qstat_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fvp_front.sv
// ----------------------------------------------------------------------------
// fvp_front
// Byte intake: header check, frame position, CRC, payload capture.
// ----------------------------------------------------------------------------
`default_nettype none

module fvp_front
    import fvp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] rx_byte,
    output fvp_push_t       push
);

    logic [3:0]  pos_reg,  pos_next;
    logic [15:0] crc_reg,  crc_next;
    logic [3:0]  b3hi_reg, b3hi_next;
    logic [7:0]  b5_reg,   b5_next;
    logic [7:0]  b6_reg,   b6_next;
    logic [7:0]  b7_reg,   b7_next;

    logic        wrapped;
    logic [3:0]  pos_cur;
    logic [15:0] crc_cur;
    logic        hdr_ok;

    assign wrapped = pos_reg > POS_LAST;
    assign pos_cur = wrapped ? POS_HDR0 : pos_reg;
    assign crc_cur = wrapped ? CRC_INIT : crc_reg;
    assign hdr_ok  = (pos_cur == POS_HDR0 && rx_byte == HDR_ADDR)
                  || (pos_cur == POS_HDR1 && rx_byte == HDR_FUNC)
                  || (pos_cur == POS_HDR2 && rx_byte == HDR_COUNT)
                  || (pos_cur >= POS_B3);

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        b3hi_next  = b3hi_reg;
        b5_next    = b5_reg;
        b6_next    = b6_reg;
        b7_next    = b7_reg;
        push.valid = 1'b0;
        push.frame.crc_match = ({rx_byte, b7_reg} == crc_cur);
        push.frame.speed_raw = {b5_reg, b6_reg, b3hi_reg};
        if (take)
        begin
            if (pos_cur == POS_LAST)
            begin
                push.valid = 1'b1;
                pos_next   = POS_HDR0;
                crc_next   = CRC_INIT;
            end
            else if (hdr_ok)
            begin
                case (pos_cur)
                    POS_B3:  b3hi_next = rx_byte[7:4];
                    POS_B5:  b5_next   = rx_byte;
                    POS_B6:  b6_next   = rx_byte;
                    POS_B7:  b7_next   = rx_byte;
                    default: ;
                endcase
                if (pos_cur <= POS_B6)
                    crc_next = crc_update(crc_cur, rx_byte);
                else
                    crc_next = crc_cur;
                pos_next = 4'(pos_cur + 4'd1);
            end
            else
            begin
                pos_next = pos_cur;
                crc_next = crc_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HDR0;
            crc_reg <= CRC_INIT;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b3hi_reg <= b3hi_next;
        b5_reg   <= b5_next;
        b6_reg   <= b6_next;
        b7_reg   <= b7_next;
    end

endmodule

`default_nettype wire

FILE: hdl/fvp_queue.sv
// ----------------------------------------------------------------------------
// fvp_queue
// Two-entry frame queue between intake and velocity scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module fvp_queue
    import fvp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire fvp_push_t  push,
    input  wire logic       pop,
    output fvp_frame_t      head,
    output fvp_qstat_t      stat
);

    fvp_frame_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.valid = count_reg != 2'd0;
    assign stat.full  = count_reg == 2'd2;

    always_comb
    begin
        wr_ptr_next = push.valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
            count_next = 2'(count_reg + 2'd1);
        else if (pop && !push.valid)
            count_next = 2'(count_reg - 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entry_reg[wr_ptr_reg] <= push.frame;
    end

endmodule

`default_nettype wire

FILE: hdl/fvp_back.sv
// ----------------------------------------------------------------------------
// fvp_back
// Velocity scaling pipeline: x25, divide by 109 via reciprocal, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module fvp_back
    import fvp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fvp_frame_t        head,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   crc_match,
    output logic signed [15:0]     velocity
);

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic              s1_crc_reg,   s2_crc_reg,   s3_crc_reg;
    logic              s1_neg_reg,   s2_neg_reg;
    logic [MAG_W-1:0]  s1_mag_reg;
    logic [QUO_W-1:0]  s2_quo_reg;
    logic signed [15:0] s3_vel_reg;

    logic              adv1, adv2, adv3;
    logic signed [SCL_W-1:0] scaled;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic signed [QUO_W:0]   sq;
    logic signed [15:0] vel_sat;

    assign adv3 = !s3_valid_reg || !out_stall;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign pop  = head_valid && adv1;

    assign scaled = SCL_W'(signed'(head.speed_raw)) * SCALE_MUL;
    assign mag    = scaled[SCL_W-1] ? MAG_W'(-scaled) : scaled[MAG_W-1:0];
    assign prod   = PROD_W'(s1_mag_reg) * PROD_W'(DIV_RECIP);
    assign sq     = s2_neg_reg ? -signed'({1'b0, s2_quo_reg}) : signed'({1'b0, s2_quo_reg});

    always_comb
    begin
        if (sq > VEL_MAX)
            vel_sat = 16'(VEL_MAX);
        else if (sq < VEL_MIN)
            vel_sat = 16'(VEL_MIN);
        else
            vel_sat = sq[15:0];
    end

    assign out_valid = s3_valid_reg;
    assign crc_match = s3_crc_reg;
    assign velocity  = s3_vel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= head_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_crc_reg <= head.crc_match;
            s1_neg_reg <= scaled[SCL_W-1];
            s1_mag_reg <= mag;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_crc_reg <= s1_crc_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_quo_reg <= prod[RCP_SH+QUO_W-1:RCP_SH];
        end
        if (adv3 && s2_valid_reg)
        begin
            s3_crc_reg <= s2_crc_reg;
            s3_vel_reg <= vel_sat;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/modbus_velocity_frame_parser.sv
// ----------------------------------------------------------------------------
// modbus_velocity_frame_parser: Modbus read response parser with CRC16 check
// Throughput: one byte per cycle; stalls only while the frame queue is full.
// Result path: a frame completed by its ninth byte is queued, then registered through s1, s2 and s3 to out_valid.
// Reset: async active low; clears position, CRC to 0xFFFF, queue and pipe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_velocity_frame_parser_macros.svh"

module modbus_velocity_frame_parser
    import fvp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   crc_match,
    output logic signed [15:0]     velocity
);

    fvp_push_t  push;
    fvp_frame_t head;
    fvp_qstat_t qstat;
    logic       take;
    logic       pop;

    assign in_stall = qstat.full;
    assign take     = in_valid && !in_stall;

    fvp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .push    (push)
    );

    fvp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (qstat)
    );

    fvp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (qstat.valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .crc_match  (crc_match),
        .velocity   (velocity)
    );

    `FVP_ASSERT_NOW(a_no_push_full, clk, rst_n, push.valid, !qstat.full)
    `FVP_ASSERT_NOW(a_pop_has_entry, clk, rst_n, pop, qstat.valid)
    `FVP_ASSERT_NEXT(a_push_fills, clk, rst_n, push.valid && !qstat.valid, qstat.valid)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for modbus_velocity_frame_parser
// Feeds serial bytes as directed and random Modbus read responses, predicts
// each frame's CRC flag and scaled velocity in step with the input, and
// checks every output transaction in order. Random bursts and gaps on the
// input side, a random stall pattern and one long hold on the output side.
// ----------------------------------------------------------------------------
module tb_top;
    import fvp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 680;

    typedef struct {
        logic               crc_ok;
        logic signed [15:0] speed;
    } speed_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               crc_match;
    logic signed [15:0] velocity;

    // predictor state
    logic [3:0]  frame_pos = 4'd0;
    logic [15:0] crc_acc = 16'hFFFF;
    logic [7:0]  rx_payload [5];

    speed_result_t expected_speed_q[$];

    int  err_count = 0;
    int  used_items = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;
    int  burst_left = 0;
    bit  stall_on = 1'b0;
    bit  stall_now = 1'b0;
    int  run_left = 0;
    bit  hold_go = 1'b0;
    int  hold_left = 0;

    modbus_velocity_frame_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .crc_match (crc_match),
        .velocity  (velocity)
    );

    always #2 clk = ~clk;

    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] scaled_speed(input logic [7:0] b3, input logic [7:0] b4,
                                                        input logic [7:0] b5, input logic [7:0] b6);
        logic signed [31:0] word;
        int raw;
        int q;
        word = {b5, b6, b3, b4};
        raw  = word >>> 12;
        q    = (raw * 25) / 109;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic void note_failure(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // returns 1 when the byte advances the frame or completes it
    function automatic bit parse_rx_byte(input logic [7:0] b);
        speed_result_t r;
        bit used;
        used = 1'b0;
        if (frame_pos == POS_LAST)
        begin
            r.crc_ok = ({b, rx_payload[4]} == crc_acc);
            r.speed  = scaled_speed(rx_payload[0], rx_payload[1], rx_payload[2], rx_payload[3]);
            expected_speed_q.push_back(r);
            frame_pos = POS_HDR0;
            crc_acc   = CRC_INIT;
            used      = 1'b1;
        end
        else if ((frame_pos == POS_HDR0 && b == HDR_ADDR) ||
                 (frame_pos == POS_HDR1 && b == HDR_FUNC) ||
                 (frame_pos == POS_HDR2 && b == HDR_COUNT) || frame_pos >= POS_B3)
        begin
            if (frame_pos >= POS_B3)
                rx_payload[3'(frame_pos - POS_B3)] = b;
            if (frame_pos <= POS_B6)
                crc_acc = crc16_next(crc_acc, b);
            frame_pos = frame_pos + 4'd1;
            used      = 1'b1;
        end
        return used;
    endfunction

    function automatic logic [7:0] pick_field_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // called at a rising edge; returns at the edge of the transaction
    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit took;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(0, 12);
                burst_left = $urandom_range(1, 24);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        if (parse_rx_byte(b))
            used_items++;
    endtask

    task automatic send_frame_body(input logic [7:0] b3, input logic [7:0] b4,
                                   input logic [7:0] b5, input logic [7:0] b6, input bit crc_good);
        logic [15:0] c;
        c = CRC_INIT;
        c = crc16_next(c, HDR_ADDR);
        c = crc16_next(c, HDR_FUNC);
        c = crc16_next(c, HDR_COUNT);
        c = crc16_next(c, b3);
        c = crc16_next(c, b4);
        c = crc16_next(c, b5);
        c = crc16_next(c, b6);
        if (!crc_good)
            c = c ^ 16'($urandom_range(1, 65535));
        send_byte(b3);
        send_byte(b4);
        send_byte(b5);
        send_byte(b6);
        send_byte(c[7:0]);
        send_byte(c[15:8]);
    endtask

    task automatic send_frame(input logic [7:0] b3, input logic [7:0] b4,
                              input logic [7:0] b5, input logic [7:0] b6, input bit crc_good);
        send_byte(HDR_ADDR);
        send_byte(HDR_FUNC);
        send_byte(HDR_COUNT);
        send_frame_body(b3, b4, b5, b6, crc_good);
    endtask

    task automatic send_random_frame(input bit crc_good);
        send_frame(pick_field_byte(), pick_field_byte(), pick_field_byte(), pick_field_byte(),
                   crc_good);
    endtask

    // wrong bytes at each header position are dropped
    task automatic test_header_rejects();
        send_byte(8'hFF);
        send_byte(HDR_ADDR);
        send_byte(HDR_COUNT);
        send_byte(HDR_FUNC);
        send_byte(8'hFF);
        send_byte(HDR_COUNT);
        send_frame_body(8'hFF, 8'hFF, 8'h7F, 8'hFF, 1'b1);
    endtask

    task automatic test_velocity_limits();
        send_frame(8'h00, 8'h00, 8'h80, 8'h00, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_random_frames();
        int sel;
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        used_items = 0;
        while (used_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                send_random_frame(1'b1);
            else if (sel < 85)
                send_random_frame(1'b0);
            else if (sel < 95)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            else
            begin
                send_byte(HDR_ADDR);
                if ($urandom_range(0, 1))
                    send_byte(HDR_FUNC);
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_no_idle();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (8) send_random_frame(1'($urandom_range(0, 1)));
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_output_hold();
        gaps_on = 1'b0;
        hold_go = 1'b1;
        repeat (8) send_random_frame(1'b1);
        stall_on = 1'b1;
        gaps_on  = 1'b1;
        repeat (4) send_random_frame(1'b1);
    endtask

    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!stall_on)
            out_stall <= 1'b0;
        else
        begin
            if (run_left == 0)
            begin
                stall_now = !stall_now;
                run_left  = stall_now ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            run_left--;
            out_stall <= stall_now;
        end
    end

    // outputs are stable from the falling edge up to the next rising edge
    always @(negedge clk)
    begin
        speed_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_speed_q.size() == 0)
                note_failure($sformatf("unexpected transaction crc_match=%0b velocity=%0d",
                                       crc_match, velocity));
            else
            begin
                e = expected_speed_q.pop_front();
                if (crc_match !== e.crc_ok)
                    note_failure($sformatf("crc_match expected %0b got %0b", e.crc_ok, crc_match));
                if (velocity !== e.speed)
                    note_failure($sformatf("velocity expected %0d got %0d", e.speed, velocity));
            end
        end
    end

    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** modbus_velocity_frame_parser: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_rejects();
        test_velocity_limits();
        test_random_frames();
        test_no_idle();
        test_output_hold();
        in_valid <= 1'b0;
        stall_on = 1'b0;
        while (expected_speed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_speed_q.size() != 0)
            note_failure("results still outstanding at end of run");
        if (err_count == 0)
            $display("** modbus_velocity_frame_parser: PASSED **");
        else
            $display("** modbus_velocity_frame_parser: FAILED **");
        $finish;
    end

endmodule
